[rtl/fbd_pkg.sv]
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared constants and types of the fractional baud divider search.
// ----------------------------------------------------------------------------
package fbd_pkg;

    // Divider datapath width
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    // Field widths
    localparam int BAUD_W      = 24;
    localparam int CLK_W       = 32;
    localparam int PCT_W       = 7;
    localparam int FRAC_W      = 4;
    localparam int DIVISOR_W   = 16;
    localparam int ERR_W       = 17;
    localparam int BASE_W      = CLK_W - 6;          // core clock / 64
    localparam int NUM_W       = BASE_W + FRAC_W;    // multiplier * base
    localparam int RATE_W      = NUM_W;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 56;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_PCT = 1'd1;

    localparam logic [CLK_W-1:0] CORE_CLOCK_RST = 32'd100000000;
    localparam logic [PCT_W-1:0] ACCEPT_PCT_RST = 7'd3;

    // Search constants
    localparam logic [ERR_W-1:0]     NO_CAND_ERR = 17'd100000;
    localparam logic [DIV_W-1:0]     MIN_DIVISOR = 32'd3;
    localparam logic [FRAC_W-1:0]    MAX_FRAC    = 4'd15;
    localparam logic [DIV_W-1:0]     PCT_SCALE   = 32'd100;

    // Divider request / response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

[rtl/fbd_div.sv]
// ----------------------------------------------------------------------------
// fbd_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  fbd_pkg::div_req_t req,
    output fbd_pkg::div_rsp_t rsp
);
    import fbd_pkg::*;

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       trial;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        trial   = shifted - {1'b0, den_reg};
        if (!trial[DIV_W])
        begin
            rem_next = trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[rtl/fractional_baud_divider_search_unit.sv]
// ----------------------------------------------------------------------------
// fractional_baud_divider_search_unit
// Searches fractional multiplier / divide-add pairs for the best baud divisor.
// ----------------------------------------------------------------------------
//  channel  | dir | word contents
//  ---------+-----+-------------------------------------------------------
//  s_*      | in  | baud_rate[23:0]
//  m_*      | out | success, divisor, frac_multiplier, frac_add,
//           |     | fraction_byte, best_error
//  cfg_*    | in  | 0: core_clock_hz, 1: accepted_error_percent
//
//  Each candidate pair takes up to three passes through the shared 32-step
//  divider plus a step state; a pair whose divisor is out of range stops
//  after the second pass, the others add a compare. A full search covers
//  240 pairs and stops early when an exact pair is found. A zero baud rate
//  skips the search. s_tready is high only while idle; a finished word
//  waits in the output register, and a new search may run meanwhile.
//  No clearing pass.
// ----------------------------------------------------------------------------
module fractional_baud_divider_search_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input word: baud_rate[23:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fbd_pkg::IN_DATA_W-1:0]      s_tdata,
    // Output word: success[0], divisor[16:1], frac_multiplier[20:17],
    // frac_add[24:21], fraction_byte[32:25], best_error[49:33], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fbd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [fbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fbd_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_MUL   = 10'b00_0000_0010,
        S_DIV_T = 10'b00_0000_0100,
        S_DIV_D = 10'b00_0000_1000,
        S_DIV_R = 10'b00_0001_0000,
        S_CMP   = 10'b00_0010_0000,
        S_NEXT  = 10'b00_0100_0000,
        S_LIMIT = 10'b00_1000_0000,
        S_OUT   = 10'b01_0000_0000,
        S_SPARE = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [CLK_W-1:0]     core_clk_reg;
    logic [PCT_W-1:0]     pct_reg;

    // Search registers
    logic [BAUD_W-1:0]    baud_reg;
    logic [BAUD_W+PCT_W-1:0] prod_reg;
    logic [FRAC_W-1:0]    mul_reg;
    logic [FRAC_W-1:0]    add_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [RATE_W-1:0]    t_reg;
    logic [DIVISOR_W-1:0] d_reg;
    logic [RATE_W-1:0]    err_reg;
    logic                 launched_reg;

    // Best candidate
    logic [FRAC_W-1:0]    best_mul_reg;
    logic [FRAC_W-1:0]    best_add_reg;
    logic [DIVISOR_W-1:0] best_div_reg;
    logic [ERR_W-1:0]     best_err_reg;
    logic                 success_reg;

    // Output register
    logic                 o_valid_reg;
    logic                 o_succ_reg;
    logic [DIVISOR_W-1:0] o_div_reg;
    logic [FRAC_W-1:0]    o_mul_reg;
    logic [FRAC_W-1:0]    o_add_reg;
    logic [ERR_W-1:0]     o_err_reg;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 in_fire;
    logic                 div_state;
    logic [DIV_W-1:0]     d_sum;
    logic                 round_up;
    logic                 d_ok;
    logic [DIV_W-1:0]     baud_ext;
    logic [RATE_W-1:0]    rate;
    logic [RATE_W-1:0]    baud_rate_ext;
    logic                 out_free;
    logic [BAUD_W+PCT_W-1:0] err_inc;
    logic [BAUD_W+PCT_W-1:0] err_scaled;

    // ---------------- shared divider ----------------
    fbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_state = (state_reg == S_DIV_T) || (state_reg == S_DIV_D) ||
                       (state_reg == S_DIV_R);
    assign baud_ext  = {{(DIV_W-BAUD_W){1'b0}}, baud_reg};

    // Operand selection per division step
    always_comb
    begin
        div_req.start    = div_state && !launched_reg;
        div_req.dividend = {{(DIV_W-RATE_W){1'b0}}, t_reg};
        div_req.divisor  = baud_ext;
        unique case (state_reg)
            S_DIV_T:
            begin
                div_req.dividend = {{(DIV_W-NUM_W){1'b0}}, num_reg};
                div_req.divisor  = DIV_W'({1'b0, mul_reg} + {1'b0, add_reg});
            end
            S_DIV_R:
            begin
                div_req.divisor  = {{(DIV_W-DIVISOR_W){1'b0}}, d_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Rounded divisor and its range check
    assign round_up = div_rsp.remainder > {{(DIV_W-BAUD_W+1){1'b0}}, baud_reg[BAUD_W-1:1]};
    assign d_sum    = div_rsp.quotient + {{(DIV_W-1){1'b0}}, round_up};
    assign d_ok     = (d_sum >= MIN_DIVISOR) && (d_sum[DIV_W-1:DIVISOR_W] == '0);

    // Rate and absolute error
    assign rate          = div_rsp.quotient[RATE_W-1:0];
    assign baud_rate_ext = {{(RATE_W-BAUD_W){1'b0}}, baud_reg};

    // Threshold: err < floor(p / 100) holds exactly when 100 * (err + 1) <= p
    assign err_inc    = {{(BAUD_W+PCT_W-ERR_W){1'b0}}, best_err_reg}
                        + {{(BAUD_W+PCT_W-1){1'b0}}, 1'b1};
    assign err_scaled = (err_inc << 6) + (err_inc << 5) + (err_inc << 2);

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !o_valid_reg || m_tready;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tdata[BAUD_W-1:0] == '0)
                        state_next = S_OUT;
                    else
                        state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_DIV_T;
            S_DIV_T: if (div_rsp.done) state_next = S_DIV_D;
            S_DIV_D:
            begin
                if (div_rsp.done)
                    state_next = d_ok ? S_DIV_R : S_NEXT;
            end
            S_DIV_R: if (div_rsp.done) state_next = S_CMP;
            S_CMP:
            begin
                if (err_reg < {{(RATE_W-ERR_W){1'b0}}, best_err_reg} && err_reg == '0)
                    state_next = S_LIMIT;
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (add_reg == MAX_FRAC)
                    state_next = (mul_reg == MAX_FRAC) ? S_LIMIT : S_MUL;
                else
                    state_next = S_DIV_T;
            end
            S_LIMIT: state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_req.start)
                launched_reg <= 1'b1;
            else if (div_rsp.done)
                launched_reg <= 1'b0;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_clk_reg <= CORE_CLOCK_RST;
            pct_reg      <= ACCEPT_PCT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CORE_CLOCK: core_clk_reg <= cfg_data[CLK_W-1:0];
                CFG_ACCEPT_PCT: pct_reg      <= cfg_data[PCT_W-1:0];
                default:        core_clk_reg <= core_clk_reg;
            endcase
        end
    end

    // ---------------- search datapath ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg      <= 4'd1;
            add_reg      <= '0;
            best_mul_reg <= 4'd1;
            best_add_reg <= '0;
            best_div_reg <= '0;
            best_err_reg <= NO_CAND_ERR;
            success_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        mul_reg      <= 4'd1;
                        add_reg      <= '0;
                        best_mul_reg <= 4'd1;
                        best_add_reg <= '0;
                        best_div_reg <= '0;
                        best_err_reg <= NO_CAND_ERR;
                        success_reg  <= 1'b0;
                    end
                end
                S_CMP:
                begin
                    // keep first strictly better candidate
                    if (err_reg < {{(RATE_W-ERR_W){1'b0}}, best_err_reg})
                    begin
                        best_mul_reg <= mul_reg;
                        best_add_reg <= add_reg;
                        best_div_reg <= d_reg;
                        best_err_reg <= err_reg[ERR_W-1:0];
                    end
                end
                S_NEXT:
                begin
                    if (add_reg == MAX_FRAC)
                    begin
                        add_reg <= '0;
                        // multiplier stays at its top value after the last pair
                        if (mul_reg != MAX_FRAC)
                            mul_reg <= mul_reg + 1'b1;
                    end
                    else
                    begin
                        add_reg <= add_reg + 1'b1;
                    end
                end
                S_LIMIT:
                begin
                    success_reg <= (err_scaled <= prod_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            baud_reg <= s_tdata[BAUD_W-1:0];
            prod_reg <= {{PCT_W{1'b0}}, s_tdata[BAUD_W-1:0]} * {{BAUD_W{1'b0}}, pct_reg};
        end
        if (state_reg == S_MUL)
            num_reg <= {{BASE_W{1'b0}}, mul_reg} * {{FRAC_W{1'b0}}, core_clk_reg[CLK_W-1:6]};
        if (state_reg == S_DIV_T && div_rsp.done)
            t_reg <= div_rsp.quotient[RATE_W-1:0];
        if (state_reg == S_DIV_D && div_rsp.done)
            d_reg <= d_sum[DIVISOR_W-1:0];
        if (state_reg == S_DIV_R && div_rsp.done)
            err_reg <= (rate <= baud_rate_ext) ? (baud_rate_ext - rate)
                                               : (rate - baud_rate_ext);
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (state_reg == S_OUT && out_free)
            o_valid_reg <= 1'b1;
        else if (m_tready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            o_succ_reg <= success_reg;
            o_div_reg  <= best_div_reg;
            o_mul_reg  <= best_mul_reg;
            o_add_reg  <= best_add_reg;
            o_err_reg  <= best_err_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-50){1'b0}}, o_err_reg, o_mul_reg, o_add_reg,
                       o_add_reg, o_mul_reg, o_div_reg, o_succ_reg};

    // ---------------- assertions ----------------
    a_frac_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:25] == {m_tdata[20:17], m_tdata[24:21]})
        else $error("fraction byte does not match multiplier and add fields");

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[16:1] != 16'd0) |-> m_tdata[16:1] >= 16'd3)
        else $error("reported divisor below minimum");

    a_best_err: assert property (@(posedge clk) disable iff (!rst_n)
        best_err_reg <= NO_CAND_ERR)
        else $error("best error above no-candidate value");

    a_mul_nz: assert property (@(posedge clk) disable iff (!rst_n)
        mul_reg != '0 && best_mul_reg != '0)
        else $error("fractional multiplier reached zero");

endmodule

[sim/fractional_baud_divider_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// fractional_baud_divider_search_unit_tb
// Self-checking bench for the fractional baud divider search. Baud rate words
// go in on the input stream. A local model finds the best multiplier and
// divide-add pair for each one, and every result word is checked field by
// field. The run covers several core clock and tolerance settings, random
// stalls on both streams and a long output stall.
// ----------------------------------------------------------------------------
module fractional_baud_divider_search_unit_tb;
    import fbd_pkg::*;

    localparam int              CLK_HALF      = 10;
    localparam int              RST_CYCLES    = 6;
    localparam longint unsigned BASE_DIV      = 64;
    localparam longint unsigned DIVISOR_LIMIT = 65536;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              IDLE_LIMIT    = 150000;
    localparam int              DRAIN_CYCLES  = 200;
    localparam int              RANDOM_ITEMS  = 80;
    localparam int              QUIET_ITEMS   = 15;

    // One result word, unpacked
    typedef struct packed {
        logic                 success;
        logic [DIVISOR_W-1:0] divisor;
        logic [FRAC_W-1:0]    frac_mul;
        logic [FRAC_W-1:0]    frac_add;
        logic [7:0]           fraction_byte;
        logic [ERR_W-1:0]     best_error;
    } baud_result_t;

    // DUT connections
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Local copy of the registers
    logic [CLK_W-1:0]      core_hz    = CORE_CLOCK_RST;
    logic [PCT_W-1:0]      accept_pct = ACCEPT_PCT_RST;

    baud_result_t          pending_results[$];
    int                    errors      = 0;
    int                    idle_cycles = 0;
    bit                    quiet       = 1'b0;
    bit                    hold_req    = 1'b0;
    bit                    rx_holding  = 1'b0;

    always #CLK_HALF clk = ~clk;

    fractional_baud_divider_search_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),      // baud_rate[23:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),      // success, divisor, frac_multiplier, frac_add,
                                  // fraction_byte, best_error, zero pad
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Best divider pair for one baud rate under the current registers
    function automatic baud_result_t predict_divider(input logic [BAUD_W-1:0] baud);
        baud_result_t    res;
        longint unsigned bd, base, t, d, rate, err, best_err, best_div, lim;
        int unsigned     m, a, best_m, best_a;
        bit              exact;
        bd       = baud;
        base     = core_hz / BASE_DIV;
        best_m   = 1;
        best_a   = 0;
        best_div = 0;
        best_err = NO_CAND_ERR;
        exact    = 1'b0;
        res.success = 1'b0;
        if (bd != 0)
        begin
            for (m = 1; m <= MAX_FRAC && !exact; m++)
            begin
                for (a = 0; a <= MAX_FRAC && !exact; a++)
                begin
                    t = (m * base) / (m + a);
                    d = t / bd;
                    // round half down on the remainder
                    if ((t % bd) > (bd / 2))
                        d++;
                    if (d >= MIN_DIVISOR && d < DIVISOR_LIMIT)
                    begin
                        rate = t / d;
                        err  = (rate <= bd) ? (bd - rate) : (rate - bd);
                        // first pair wins on a tie; exact pair ends the search
                        if (err < best_err)
                        begin
                            best_m   = m;
                            best_a   = a;
                            best_div = d;
                            best_err = err;
                            if (err == 0)
                                exact = 1'b1;
                        end
                    end
                end
            end
            lim = (bd * accept_pct) / PCT_SCALE;
            res.success = (best_err < lim);
        end
        res.divisor       = best_div[DIVISOR_W-1:0];
        res.frac_mul      = best_m[FRAC_W-1:0];
        res.frac_add      = best_a[FRAC_W-1:0];
        res.fraction_byte = {best_m[FRAC_W-1:0], best_a[FRAC_W-1:0]};
        res.best_error    = best_err[ERR_W-1:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // Result checker: compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        baud_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("success",         want.success,       m_tdata[0]);
                check_field("divisor",         want.divisor,       m_tdata[16:1]);
                check_field("frac_multiplier", want.frac_mul,      m_tdata[20:17]);
                check_field("frac_add",        want.frac_add,      m_tdata[24:21]);
                check_field("fraction_byte",   want.fraction_byte, m_tdata[32:25]);
                check_field("best_error",      want.best_error,    m_tdata[49:33]);
                check_field("zero_pad",        0,                  m_tdata[55:50]);
            end
        end
    end

    // Watchdog on cycles with no word moving on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Output side ready: random bursts, long hold on request, steady when quiet
    initial
    begin : rx_side
        int burst;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                rx_holding = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_holding = 1'b0;
                m_tready <= 1'b1;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    burst = $urandom_range(1, 12);
                    m_tready <= 1'b0;
                end
                else
                begin
                    burst = $urandom_range(1, 40);
                    m_tready <= 1'b1;
                end
                repeat (burst - 1) @(posedge clk);
            end
        end
    end

    // Offer one baud rate word and record its prediction once taken
    task automatic send_baud(input logic [BAUD_W-1:0] baud);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= baud;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_divider(baud));
    endtask

    // Stop sending until every outstanding result has arrived
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == CFG_CORE_CLOCK)
            core_hz = value;
        else
            accept_pct = value[PCT_W-1:0];
    endtask

    // Register writes only with the block idle
    task automatic set_config(input logic [CLK_W-1:0] hz, input logic [PCT_W-1:0] pct);
        wait_results();
        write_reg(CFG_CORE_CLOCK, hz);
        write_reg(CFG_ACCEPT_PCT, CFG_DATA_W'(pct));
    endtask

    // Reset register values: zero rate, exact pairs, field extremes
    task automatic test_reset_values();
        send_baud(24'd0);
        send_baud(24'd1);
        send_baud(24'd9600);
        send_baud(24'd115200);
        send_baud(24'd15625);      // exact at the first pair
        send_baud(24'd390625);     // exact, small divisor
        send_baud(24'd520833);     // rounds to the minimum divisor
        send_baud(24'hFFFFFF);
        send_baud(24'hAAAAAA);
        send_baud(24'h555555);
    endtask

    // Register extremes, tolerance above 100 percent, no candidate at all
    task automatic test_register_extremes();
        set_config(32'd0, 7'd0);
        send_baud(24'd9600);
        send_baud(24'hFFFFFF);
        set_config(32'hFFFFFFFF, 7'd100);
        send_baud(24'd115200);
        send_baud(24'd1000000);
        send_baud(24'hFFFFFF);
        // no candidate, yet the threshold passes with a large tolerance
        set_config(32'hAAAAAAAA, 7'd127);
        send_baud(24'hFFFFFF);
        send_baud(24'd1);
        set_config(32'h55555555, 7'd0);
        send_baud(24'd300);
        set_config(CORE_CLOCK_RST, ACCEPT_PCT_RST);
    endtask

    // Long output stall while input keeps coming: block fills and stalls input
    task automatic test_backpressure();
        wait_results();
        hold_req = 1'b1;
        while (!rx_holding)
            @(posedge clk);
        send_baud(24'd0);
        send_baud(24'd0);
        send_baud(24'd15625);
        send_baud(24'd0);
        while (rx_holding)
            @(posedge clk);
        wait_results();
    endtask

    // Random rates over random register settings
    task automatic test_random_bauds();
        int              i;
        int unsigned     m, a, k;
        longint unsigned base, rate;
        logic [CLK_W-1:0] hz;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i > 0 && i % 25 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: hz = $urandom;
                    1: hz = CORE_CLOCK_RST;
                    2: hz = ($urandom_range(0, 1) == 0) ? 32'd12000000 : 32'd48000000;
                    default: hz = $urandom_range(0, 10000);
                endcase
                set_config(hz, PCT_W'($urandom_range(0, 127)));
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            else if ($urandom_range(0, 24) == 0)
                wait_results();
            base = core_hz / BASE_DIV;
            case ($urandom_range(0, 9))
                0, 1:
                    rate = (($urandom_range(0, 1) == 0) ? 300 : 14400) << $urandom_range(0, 6);
                2, 3, 4:
                begin
                    // rate near an achievable one, often an exact pair
                    m = $urandom_range(1, 15);
                    a = $urandom_range(0, 15);
                    k = $urandom_range(3, 4000);
                    rate = ((m * base) / (m + a)) / k;
                end
                5, 6:
                    rate = $urandom;
                7:
                    rate = $urandom_range(1, 400);
                8:
                    rate = $urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 23);
                default:
                    rate = 0;
            endcase
            send_baud(rate[BAUD_W-1:0]);
        end
    endtask

    initial
    begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_register_extremes();
        test_backpressure();
        test_random_bauds();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
